// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/werap_pkg.sv =====
// package with widths, command codes and defaults of the event rate counter
`default_nettype none
package werap_pkg;
  localparam int NUM_BINS_DEF = 16;
  localparam int LEN_W = 15;
  localparam int TIME_W = 31;
  localparam int CNT_W = 32;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EVENT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
endpackage
`default_nettype wire

// ===== hw/rtl/werap_if.sv =====
// command and result channel interfaces
`default_nettype none
interface werap_in_if import werap_pkg::*;;
  logic valid;
  logic ready;
  logic [CMD_W-1:0] cmd;
  logic [TIME_W-1:0] time_now;
  modport source(output valid, output cmd, output time_now, input ready);
  modport sink(input valid, input cmd, input time_now, output ready);
endinterface

interface werap_out_if import werap_pkg::*;;
  logic valid;
  logic ready;
  logic [CNT_W-1:0] average_count;
  logic [CNT_W-1:0] peak_count;
  modport source(output valid, output average_count, output peak_count, input ready);
  modport sink(input valid, input average_count, input peak_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/windowed_event_rate_average_peak_top.sv =====
// windowed event rate counter: ring of bins in memory, average and peak on query
// One command at a time. After reset the bin memory is cleared before the first
// command is taken. A restart clears every bin. Unless it is ignored or answered
// with zeros, an event or a query first divides the elapsed time by the interval
// length on a shared serial divider (NUM_W = 49 + log2(NUM_BINS) bits), then clears
// one bin per cycle for each interval the window moved (at most NUM_BINS). An event
// then reads and writes back its bin. A query reads the used bins one per cycle,
// multiplies in S_MUL1 and S_MUL2 and, unless the divisor is below the interval
// length, runs a second division.
`default_nettype none
`include "assert_macros.svh"
module windowed_event_rate_average_peak_top import werap_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [LEN_W-1:0]  cfg_wr_data,
  werap_in_if.sink               in_ch,
  werap_out_if.source            out_ch
);
  localparam int PTR_W = $clog2(NUM_BINS);
  localparam int USED_W = $clog2(NUM_BINS + 1);
  localparam int SUM_W = CNT_W + $clog2(NUM_BINS);
  localparam int D_W = LEN_W + $clog2(NUM_BINS);
  localparam int PROD_W = SUM_W + LEN_W;
  localparam int NUM_W = PROD_W + 2;
  localparam int DIV_DW = D_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV1 = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_DISP = 4'd3;
  localparam logic [3:0] S_EVRD = 4'd4;
  localparam logic [3:0] S_EVWR = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_MUL1 = 4'd7;
  localparam logic [3:0] S_MUL2 = 4'd8;
  localparam logic [3:0] S_DEC  = 4'd9;
  localparam logic [3:0] S_DIV2 = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]        state;
  logic [LEN_W-1:0]  interval_length;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] newest_interval;
  logic [USED_W-1:0] used_bins;
  logic [PTR_W-1:0]  head;
  logic [USED_W-1:0] clr_cnt;
  logic [CMD_W-1:0]  cur_cmd;
  logic [LEN_W-1:0]  frac;
  logic [PTR_W-1:0]  rptr;
  logic [USED_W-1:0] sidx;
  logic              rd_v;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  peak;
  logic [PROD_W-1:0] prod;
  logic [D_W-1:0]    dval;
  logic [CNT_W-1:0]  res_avg;
  logic [CNT_W-1:0]  res_peak;

  logic [CNT_W-1:0]  mem [NUM_BINS];
  logic [CNT_W-1:0]  rd_data;
  logic [PTR_W-1:0]  rd_addr;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [CNT_W-1:0]  wr_data;

  logic              dv_start;
  logic [NUM_W-1:0]  dv_num;
  logic [DIV_DW-1:0] dv_den;
  logic              dv_busy;
  logic              dv_done;
  logic [NUM_W-1:0]  dv_quo;
  logic [DIV_DW-1:0] dv_rem;

  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  rptr_dec;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] target;
  logic [TIME_W-1:0] shift_dist;
  logic [USED_W-1:0] step_cnt;
  logic [USED_W:0]   used_sum;
  logic [LEN_W:0]    rem_inc;
  logic              issuing;
  logic [D_W-1:0]    d_full;
  logic [CNT_W-1:0]  bin_inc;

  werap_div #(.NW(NUM_W), .DW(DIV_DW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .done(dv_done), .quo(dv_quo), .rem(dv_rem)
  );

  always_comb begin
    head_inc = (head == PTR_W'(NUM_BINS - 1)) ? '0 : head + 1'b1;
    rptr_dec = (rptr == '0) ? PTR_W'(NUM_BINS - 1) : rptr - 1'b1;
    elapsed = (in_ch.time_now >= start_time) ? in_ch.time_now - start_time : '0;
    target = dv_quo[TIME_W-1:0];
    shift_dist = target - newest_interval;
    step_cnt = (shift_dist >= TIME_W'(NUM_BINS)) ? USED_W'(NUM_BINS)
                                                 : shift_dist[USED_W-1:0];
    used_sum = {1'b0, used_bins} + {1'b0, step_cnt};
    rem_inc = {1'b0, dv_rem[LEN_W-1:0]} + 1'b1;
    issuing = (sidx < used_bins);
    d_full = D_W'(frac) + D_W'(used_bins - 1'b1) * D_W'(interval_length);
    bin_inc = (rd_data == '1) ? rd_data : rd_data + 1'b1;
    rd_addr = (state == S_SUM) ? rptr : head;
    wr_en = (state == S_CLR) || (state == S_EVWR);
    wr_addr = (state == S_CLR) ? head_inc : head;
    wr_data = (state == S_CLR) ? '0 : bin_inc;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_length <= '0;
    end else if (cfg_wr_en) begin
      interval_length <= cfg_wr_data;
    end
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= USED_W'(NUM_BINS);
      cur_cmd <= CMD_RESTART;
      start_time <= '0;
      newest_interval <= '0;
      used_bins <= '0;
      head <= '0;
      rd_v <= 1'b0;
      dv_start <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      dv_start <= 1'b0;
      if (out_ch.valid && out_ch.ready && (state != S_OUT)) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur_cmd <= in_ch.cmd;
            dv_num <= NUM_W'(elapsed);
            dv_den <= DIV_DW'(interval_length);
            case (in_ch.cmd)
              CMD_RESTART: begin
                start_time <= in_ch.time_now;
                newest_interval <= '0;
                used_bins <= USED_W'(1);
                clr_cnt <= USED_W'(NUM_BINS);
                state <= S_CLR;
              end
              CMD_EVENT: begin
                if (start_time != '0 && interval_length != '0 && in_ch.time_now != '0) begin
                  dv_start <= 1'b1;
                  state <= S_DIV1;
                end
              end
              CMD_QUERY: begin
                if (start_time == '0 || used_bins == '0 || interval_length == '0) begin
                  res_avg <= '0;
                  res_peak <= '0;
                  state <= S_OUT;
                end else begin
                  dv_start <= 1'b1;
                  state <= S_DIV1;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DIV1: begin
          if (dv_done) begin
            frac <= (rem_inc == {1'b0, interval_length}) ? '0 : rem_inc[LEN_W-1:0];
            if (target > newest_interval) begin
              newest_interval <= target;
              clr_cnt <= step_cnt;
              used_bins <= (used_sum > (USED_W + 1)'(NUM_BINS)) ? USED_W'(NUM_BINS)
                                                               : used_sum[USED_W-1:0];
              state <= S_CLR;
            end else begin
              state <= S_DISP;
            end
          end
        end
        S_CLR: begin
          head <= head_inc;
          clr_cnt <= clr_cnt - 1'b1;
          if (clr_cnt == USED_W'(1)) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          rptr <= head;
          sidx <= '0;
          sum <= '0;
          peak <= '0;
          rd_v <= 1'b0;
          case (cur_cmd)
            CMD_EVENT: state <= S_EVRD;
            CMD_QUERY: state <= S_SUM;
            default:   state <= S_IDLE;
          endcase
        end
        S_EVRD: begin
          state <= S_EVWR;
        end
        S_EVWR: begin
          state <= S_IDLE;
        end
        S_SUM: begin
          rd_v <= issuing;
          if (issuing) begin
            sidx <= sidx + 1'b1;
            rptr <= rptr_dec;
          end
          if (rd_v) begin
            sum <= sum + SUM_W'(rd_data);
            if (rd_data > peak) begin
              peak <= rd_data;
            end
          end
          if (!issuing && !rd_v) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          dval <= d_full;
          prod <= PROD_W'(sum[CNT_W-1:0]) * PROD_W'(interval_length);
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod <= prod + ((PROD_W'(sum[SUM_W-1:CNT_W]) * PROD_W'(interval_length)) << CNT_W);
          state <= S_DEC;
        end
        S_DEC: begin
          res_peak <= peak;
          if (dval == '0) begin
            res_avg <= '0;
            state <= S_OUT;
          end else if (dval < D_W'(interval_length)) begin
            res_avg <= (sum[SUM_W-1:CNT_W] != '0) ? '1 : sum[CNT_W-1:0];
            state <= S_OUT;
          end else begin
            dv_num <= NUM_W'({prod, 1'b0}) + NUM_W'(dval);
            dv_den <= {dval, 1'b0};
            dv_start <= 1'b1;
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (dv_done) begin
            res_avg <= (dv_quo[NUM_W-1:CNT_W] != '0) ? '1 : dv_quo[CNT_W-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.average_count <= res_avg;
            out_ch.peak_count <= res_peak;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_used_range, clk, rst, used_bins <= USED_W'(NUM_BINS), "used bins out of range")
  `ASSERT_ALWAYS(a_head_range, clk, rst, head <= PTR_W'(NUM_BINS - 1), "head pointer out of range")
  `ASSERT_IMPL(a_clr_cnt, clk, rst, state == S_CLR, clr_cnt != '0, "clear sweep with zero count")
  `ASSERT_IMPL(a_div_wait, clk, rst, (state == S_DIV1) || (state == S_DIV2),
               dv_busy || dv_start || dv_done, "waiting on an idle divider")
endmodule
`default_nettype wire

// ===== hw/rtl/werap_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
`include "assert_macros.svh"
module werap_div import werap_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic               done,
  output logic [NW-1:0]      quo,
  output logic [DW-1:0]      rem
);
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] dsr;
  logic [DW:0]   trial;
  logic          qbit;

  always_comb begin
    trial = {rem, quo[NW-1]};
    qbit = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
        quo <= num;
        rem <= '0;
        dsr <= den;
      end else if (busy) begin
        rem <= qbit ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
        quo <= {quo[NW-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_IMPL(a_no_restart, clk, rst, start, !busy, "divider started while busy")
  `ASSERT_IMPL(a_cnt_busy, clk, rst, busy, cnt != '0, "divider busy with zero count")
  `ASSERT_NEXT(a_done_end, clk, rst, done, !busy, "divider busy after done")
endmodule
`default_nettype wire

// ===== verif/tb_windowed_event_rate_average_peak_top.sv =====
// testbench for the windowed event rate counter: directed and random commands, scoreboard check
`default_nettype none
module tb_windowed_event_rate_average_peak_top;
  import werap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = NUM_BINS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE = 400;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic [CNT_W-1:0] average_count;
    logic [CNT_W-1:0] peak_count;
  } rate_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;

  werap_in_if in_ch ();
  werap_out_if out_ch ();

  windowed_event_rate_average_peak_top DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor state
  logic [LEN_W-1:0] model_len;
  logic [TIME_W-1:0] model_start;
  logic [TIME_W-1:0] model_newest;
  int unsigned model_used;
  logic [CNT_W-1:0] model_bins [NB];

  rate_result_t expected_rates [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned queries_sent = 0;
  longint cycles = 0;
  bit long_hold = 1'b0;
  bit stall_on = 1'b0;
  logic [TIME_W-1:0] now_t = '0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  function automatic logic [TIME_W-1:0] elapsed_since_start(input logic [TIME_W-1:0] t);
    return (t >= model_start) ? t - model_start : '0;
  endfunction

  function automatic void advance_window(input logic [TIME_W-1:0] el);
    logic [TIME_W-1:0] target;
    logic [TIME_W-1:0] d;
    target = el / model_len;
    if (target <= model_newest) return;
    d = target - model_newest;
    if (d >= NB) begin
      foreach (model_bins[i]) model_bins[i] = '0;
      model_used = NB;
    end else begin
      for (int i = NB - 1; i >= int'(d); i--) model_bins[i] = model_bins[i - int'(d)];
      for (int i = 0; i < int'(d); i++) model_bins[i] = '0;
      model_used = model_used + d;
      if (model_used > NB) model_used = NB;
    end
    model_newest = target;
  endfunction

  function automatic void predict_rate(input logic [CMD_W-1:0] cmd,
                                       input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] el;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] avg;
    logic [63:0] frac;
    logic [CNT_W-1:0] peak;
    rate_result_t r;
    case (cmd)
      CMD_RESTART: begin
        foreach (model_bins[i]) model_bins[i] = '0;
        model_start = t;
        model_newest = '0;
        model_used = 1;
      end
      CMD_EVENT: begin
        if (model_start == 0 || model_len == 0 || t == 0) return;
        advance_window(elapsed_since_start(t));
        if (model_bins[0] != '1) model_bins[0] = model_bins[0] + 1;
      end
      CMD_QUERY: begin
        r = '0;
        if (model_start != 0 && model_used != 0 && model_len != 0) begin
          el = elapsed_since_start(t);
          advance_window(el);
          sum = 0;
          peak = 0;
          for (int i = 0; i < int'(model_used); i++) begin
            sum += model_bins[i];
            if (model_bins[i] > peak) peak = model_bins[i];
          end
          frac = (64'(el) + 1) % model_len;
          den = frac + 64'(model_used - 1) * model_len;
          if (den == 0) avg = 0;
          else if (den < model_len) avg = sum;
          else avg = (2 * sum * model_len + den) / (2 * den);
          if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
          r.average_count = avg[31:0];
          r.peak_count = peak;
        end
        expected_rates.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // receiver: own stall pattern, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else if (stall_on) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0) && (cycles[5:4] != 2'b11);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rate_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_rates.size() == 0) begin
        report_mismatch("unexpected result", out_ch.average_count, '0);
      end else begin
        want = expected_rates.pop_front();
        if (out_ch.average_count !== want.average_count)
          report_mismatch("average", out_ch.average_count, want.average_count);
        if (out_ch.peak_count !== want.peak_count)
          report_mismatch("peak", out_ch.peak_count, want.peak_count);
      end
    end
  end

  int burst_left = 0;

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t);
    if (stall_on) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.time_now <= t;
    do @(posedge clk); while (!in_ch.ready);
    predict_rate(cmd, t);
    if (cmd == CMD_QUERY) queries_sent++;
    items_sent++;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] len);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_len = len;
  endtask

  task automatic test_inactive;
    send_cmd(CMD_QUERY, 31'd5);
    send_cmd(CMD_EVENT, 31'd5);
    write_len(15'd4);
    send_cmd(CMD_QUERY, 31'd7);
    send_cmd(CMD_RESTART, 31'd0);
    send_cmd(CMD_EVENT, 31'd3);
    send_cmd(CMD_QUERY, 31'd3);
    send_cmd(CMD_UNUSED, 31'd9);
  endtask

  task automatic test_directed;
    write_len(15'd1);
    send_cmd(CMD_RESTART, 31'd10);
    send_cmd(CMD_QUERY, 31'd10);
    send_cmd(CMD_EVENT, 31'd10);
    send_cmd(CMD_EVENT, 31'd0);
    send_cmd(CMD_EVENT, 31'd12);
    send_cmd(CMD_QUERY, 31'd11);
    send_cmd(CMD_EVENT, 31'd5);
    send_cmd(CMD_QUERY, 31'd40);
    write_len(15'h7FFF);
    send_cmd(CMD_RESTART, 31'h7FFF_FFF0);
    send_cmd(CMD_EVENT, 31'h7FFF_FFFF);
    send_cmd(CMD_QUERY, 31'h7FFF_FFFF);
    send_cmd(CMD_RESTART, 31'd1);
    send_cmd(CMD_EVENT, 31'h7FFF_FFFF);
    send_cmd(CMD_QUERY, 31'h7FFF_FFFF);
    send_cmd(CMD_UNUSED, 31'h7FFF_FFFF);
  endtask

  task automatic random_phase(input int n, input int max_len);
    logic [CMD_W-1:0] cmd;
    write_len(LEN_W'($urandom_range(1, max_len)));
    now_t = TIME_W'($urandom_range(1, 1000));
    if ($urandom_range(0, 3) == 0) now_t = TIME_W'($urandom) | 31'h4000_0000;
    send_cmd(CMD_RESTART, now_t);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: cmd = CMD_RESTART;
        1: cmd = CMD_UNUSED;
        2, 3, 4, 5: cmd = CMD_QUERY;
        default: cmd = CMD_EVENT;
      endcase
      case ($urandom_range(0, 9))
        0: now_t = now_t - TIME_W'($urandom_range(0, 3 * max_len));
        1: now_t = now_t + TIME_W'($urandom_range(0, 20 * max_len));
        2: now_t = TIME_W'($urandom);
        default: now_t = now_t + TIME_W'($urandom_range(0, max_len / 2 + 1));
      endcase
      send_cmd(cmd, now_t);
    end
  endtask

  task automatic test_random;
    stall_on = 1'b1;
    random_phase(120, 3);
    random_phase(120, 20);
    random_phase(100, 200);
    random_phase(80, 32767);
    random_phase(80, 1);
  endtask

  task automatic test_backpressure;
    write_len(15'd2);
    send_cmd(CMD_RESTART, 31'd100);
    long_hold = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 12; i++) send_cmd(CMD_QUERY, TIME_W'(100 + i));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_RESTART;
    in_ch.time_now = '0;
    model_len = '0;
    model_start = '0;
    model_newest = '0;
    model_used = 0;
    foreach (model_bins[i]) model_bins[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_inactive();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    $display("sent %0d commands (%0d queries), checked %0d results", items_sent,
             queries_sent, results_seen);
    $display("interval lengths 0..32767, inactive, backwards time, wrap and hold-off covered");
    if (mismatches == 0 && expected_rates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
